>>> rtl/lfab_pkg.sv
package lfab_pkg;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic       load;
    rgb_t       color;
    logic [7:0] alpha;
  } blend_req_t;

  localparam logic [1:0] CMD_BLEND = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_GAMMA = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_EN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_SEL = 1'd1;

  localparam logic       GAMMA_EN_RST  = 1'b1;
  localparam logic [6:0] CURVE_SEL_RST = 7'd22;
  localparam int         MASK_STRINGS  = 7;

  // [curve][channel r,g,b][lo, mid, hi]
  localparam logic [7:0] CURVE_PTS [2][3][3] = '{
    '{'{8'd4, 8'd48, 8'd170}, '{8'd6, 8'd80, 8'd255}, '{8'd4, 8'd48, 8'd240}},
    '{'{8'd1, 8'd48, 8'd221}, '{8'd2, 8'd48, 8'd221}, '{8'd1, 8'd48, 8'd221}}
  };

  // three-point piecewise-linear curve, knee at 128
  function automatic logic [7:0] apply_curve(logic [7:0] x, logic [7:0] lo,
                                             logic [7:0] mid, logic [7:0] hi);
    logic [7:0]  slope;
    logic [6:0]  seg;
    logic [14:0] prod;
    logic [7:0]  base;
    if (x == 8'd0) begin
      return 8'd0;
    end
    if (x < 8'd128) begin
      slope = mid - lo;
      seg   = 7'(x - 8'd1);
      base  = lo;
    end else begin
      slope = hi - mid;
      seg   = x[6:0];
      base  = mid;
    end
    prod = 15'(slope) * 15'(seg);
    return base + prod[14:7];
  endfunction

endpackage

>>> rtl/lfab_ram.sv
module lfab_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1052
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/lfab_blend.sv
module lfab_blend (
  input  logic                clk,
  input  lfab_pkg::blend_req_t req,
  input  lfab_pkg::rgb_t      old_px,
  output lfab_pkg::rgb_t      res_px
);

  logic [7:0]  new_c [3];
  logic [7:0]  old_c [3];
  logic [7:0]  inv_alpha;
  logic [15:0] prod_new_r [3];
  logic [15:0] prod_old_r [3];
  logic [7:0]  lane_res [3];

  assign inv_alpha = 8'd255 - req.alpha;
  assign new_c[0] = req.color.r;
  assign new_c[1] = req.color.g;
  assign new_c[2] = req.color.b;
  assign old_c[0] = old_px.r;
  assign old_c[1] = old_px.g;
  assign old_c[2] = old_px.b;

  always_ff @(posedge clk) begin
    if (req.load) begin
      for (int i = 0; i < 3; i++) begin
        prod_new_r[i] <= 16'(new_c[i]) * 16'(req.alpha);
        prod_old_r[i] <= 16'(old_c[i]) * 16'(inv_alpha);
      end
    end
  end

  // x / 255 == (x + 1 + (x >> 8)) >> 8 for x up to 255*255
  always_comb begin
    logic [16:0] sum;
    logic [16:0] q;
    for (int i = 0; i < 3; i++) begin
      sum = 17'(prod_new_r[i]) + 17'(prod_old_r[i]);
      q   = sum + 17'd1 + 17'(sum[16:8]);
      lane_res[i] = q[15:8];
    end
  end

  assign res_px.r = lane_res[0];
  assign res_px.g = lane_res[1];
  assign res_px.b = lane_res[2];

endmodule

>>> rtl/lfab_gamma.sv
module lfab_gamma (
  input  lfab_pkg::rgb_t pix,
  input  logic           curve_sel,
  output lfab_pkg::rgb_t res
);

  assign res.r = lfab_pkg::apply_curve(pix.r, lfab_pkg::CURVE_PTS[curve_sel][0][0],
                   lfab_pkg::CURVE_PTS[curve_sel][0][1], lfab_pkg::CURVE_PTS[curve_sel][0][2]);
  assign res.g = lfab_pkg::apply_curve(pix.g, lfab_pkg::CURVE_PTS[curve_sel][1][0],
                   lfab_pkg::CURVE_PTS[curve_sel][1][1], lfab_pkg::CURVE_PTS[curve_sel][1][2]);
  assign res.b = lfab_pkg::apply_curve(pix.b, lfab_pkg::CURVE_PTS[curve_sel][2][0],
                   lfab_pkg::CURVE_PTS[curve_sel][2][1], lfab_pkg::CURVE_PTS[curve_sel][2][2]);

endmodule

>>> rtl/led_frame_alpha_blend_gamma_top.sv
// channel   signals                                         direction
// in        in_valid/in_ready, in_command, in_pixel,        input
//           in_red, in_green, in_blue, in_alpha
// out       out_valid/out_ready, out_red, out_green,        output
//           out_blue, out_status
// cfg       cfg_valid/cfg_ready, cfg_index, cfg_data        input
//
// One item at a time; all pixel state sits in one frame RAM (registered read).
// Paths to S_DONE: read via S_RDATA; blend via S_MUL, S_WB (read, multiply, write
// back); out-of-range and gamma disabled direct; clear sweeps all slots; gamma
// runs S_GAM (one slot per cycle through the RAM read/modify/write loop), S_GLAST.
// After reset a clear sweep over all NUM_SLOTS slots runs with in_ready low.
// A finished result sits in the output register; a new beat is taken while it waits.
module led_frame_alpha_blend_gamma_top #(
  parameter int PIXELS_PER_STRING = 150,
  parameter int LEFT_STRINGS      = 4,
  parameter int RIGHT_STRINGS     = 3,
  parameter int GUARD_SLOTS       = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_command,
  input  logic [10:0]                       in_pixel,
  input  logic [7:0]                        in_red,
  input  logic [7:0]                        in_green,
  input  logic [7:0]                        in_blue,
  input  logic [7:0]                        in_alpha,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  output logic                              out_status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lfab_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lfab_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int NUM_LEFT  = LEFT_STRINGS * PIXELS_PER_STRING;
  localparam int NUM_VIS   = NUM_LEFT + RIGHT_STRINGS * PIXELS_PER_STRING;
  localparam int NUM_SLOTS = NUM_VIS + 2 * GUARD_SLOTS;
  localparam int AW        = $clog2(NUM_SLOTS);
  localparam int POS_W     = $clog2(PIXELS_PER_STRING + 1);
  localparam int STR_W     = $clog2(LEFT_STRINGS + RIGHT_STRINGS + 1);
  localparam int RGB_W     = $bits(lfab_pkg::rgb_t);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_CLEAR = 9'b000000100,
    S_GAM   = 9'b000001000,
    S_GLAST = 9'b000010000,
    S_RDATA = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_WB    = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  function automatic logic [AW-1:0] pix_slot(logic [10:0] p);
    int pi;
    pi = int'(p);
    if (pi < NUM_LEFT) begin
      return AW'(NUM_LEFT + GUARD_SLOTS - 1 - pi);
    end
    return AW'(pi + 2 * GUARD_SLOTS);
  endfunction

  function automatic logic [AW-1:0] vis_slot(logic [AW-1:0] v);
    int vi;
    vi = int'(v);
    if (vi < NUM_LEFT) begin
      return AW'(vi + GUARD_SLOTS);
    end
    return AW'(vi + 2 * GUARD_SLOTS);
  endfunction

  state_t               state_r, state_nxt;
  logic [AW-1:0]        cnt_r, cnt_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [STR_W-1:0]     str_r, str_nxt;
  logic                 g_vld_r, g_vld_nxt;
  logic [AW-1:0]        g_addr_r, g_addr_nxt;
  logic                 g_sel_r, g_sel_nxt;
  logic [AW-1:0]        slot_r, slot_nxt;
  lfab_pkg::rgb_t       color_r, color_nxt;
  logic [7:0]           alpha_r, alpha_nxt;
  lfab_pkg::rgb_t       res_rgb_r, res_rgb_nxt;
  logic                 res_status_r, res_status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  lfab_pkg::rgb_t       out_rgb_r, out_rgb_nxt;
  logic                 out_status_r, out_status_nxt;
  logic                 gamma_en_r;
  logic [6:0]           curve_sel_r;

  logic                 out_free;
  logic                 str_sel;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [RGB_W-1:0]     mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [RGB_W-1:0]     mem_rdata;
  lfab_pkg::rgb_t       rd_px;
  lfab_pkg::rgb_t       gamma_px;
  lfab_pkg::rgb_t       blend_px;
  lfab_pkg::blend_req_t blend_req;

  assign rd_px    = mem_rdata;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // strings past the mask width use the first curve
  assign str_sel = (int'(str_r) < lfab_pkg::MASK_STRINGS) ? curve_sel_r[3'(str_r)] : 1'b0;

  assign blend_req.load  = (state_r == S_MUL);
  assign blend_req.color = color_r;
  assign blend_req.alpha = alpha_r;

  lfab_ram #(
    .WIDTH (RGB_W),
    .DEPTH (NUM_SLOTS)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  lfab_blend u_blend (
    .clk    (clk),
    .req    (blend_req),
    .old_px (rd_px),
    .res_px (blend_px)
  );

  lfab_gamma u_gamma (
    .pix       (rd_px),
    .curve_sel (g_sel_r),
    .res       (gamma_px)
  );

  always_comb begin
    mem_raddr = (state_r == S_IDLE) ? pix_slot(in_pixel) : vis_slot(cnt_r);
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = '0;
    case (state_r)
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_GAM, S_GLAST: begin
        mem_we    = g_vld_r;
        mem_waddr = g_addr_r;
        mem_wdata = gamma_px;
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = slot_r;
        mem_wdata = blend_px;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    str_nxt        = str_r;
    g_vld_nxt      = g_vld_r;
    g_addr_nxt     = g_addr_r;
    g_sel_nxt      = g_sel_r;
    slot_nxt       = slot_r;
    color_nxt      = color_r;
    alpha_nxt      = alpha_r;
    res_rgb_nxt    = res_rgb_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_rgb_nxt    = out_rgb_r;
    out_status_nxt = out_status_r;
    case (state_r)
      S_INIT, S_CLEAR: begin
        if (cnt_r == AW'(NUM_SLOTS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          slot_nxt       = pix_slot(in_pixel);
          color_nxt      = '{r: in_red, g: in_green, b: in_blue};
          alpha_nxt      = in_alpha;
          res_rgb_nxt    = '0;
          res_status_nxt = 1'b0;
          cnt_nxt        = '0;
          pos_nxt        = '0;
          str_nxt        = '0;
          g_vld_nxt      = 1'b0;
          case (in_command)
            lfab_pkg::CMD_CLEAR: begin
              state_nxt = S_CLEAR;
            end
            lfab_pkg::CMD_GAMMA: begin
              state_nxt = gamma_en_r ? S_GAM : S_DONE;
            end
            default: begin
              if (int'(in_pixel) >= NUM_VIS) begin
                res_status_nxt = 1'b1;
                state_nxt      = S_DONE;
              end else if (in_command == lfab_pkg::CMD_BLEND) begin
                state_nxt = S_MUL;
              end else begin
                state_nxt = S_RDATA;
              end
            end
          endcase
        end
      end
      S_GAM: begin
        // read slot n while slot n-1 is written back
        g_vld_nxt  = 1'b1;
        g_addr_nxt = vis_slot(cnt_r);
        g_sel_nxt  = str_sel;
        if (cnt_r == AW'(NUM_VIS - 1)) begin
          state_nxt = S_GLAST;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          if (pos_r == POS_W'(PIXELS_PER_STRING - 1)) begin
            pos_nxt = '0;
            str_nxt = str_r + 1'b1;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      S_GLAST: begin
        g_vld_nxt = 1'b0;
        state_nxt = S_DONE;
      end
      S_RDATA: begin
        res_rgb_nxt = rd_px;
        state_nxt   = S_DONE;
      end
      S_MUL: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        res_rgb_nxt = blend_px;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_rgb_nxt    = res_rgb_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      pos_r       <= '0;
      str_r       <= '0;
      g_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      gamma_en_r  <= lfab_pkg::GAMMA_EN_RST;
      curve_sel_r <= lfab_pkg::CURVE_SEL_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      str_r       <= str_nxt;
      g_vld_r     <= g_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          lfab_pkg::CFG_GAMMA_EN:  gamma_en_r  <= cfg_data[0];
          lfab_pkg::CFG_CURVE_SEL: curve_sel_r <= cfg_data;
          default: begin
            gamma_en_r <= gamma_en_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    g_addr_r     <= g_addr_nxt;
    g_sel_r      <= g_sel_nxt;
    slot_r       <= slot_nxt;
    color_r      <= color_nxt;
    alpha_r      <= alpha_nxt;
    res_rgb_r    <= res_rgb_nxt;
    res_status_r <= res_status_nxt;
    out_rgb_r    <= out_rgb_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_red    = out_rgb_r.r;
  assign out_green  = out_rgb_r.g;
  assign out_blue   = out_rgb_r.b;
  assign out_status = out_status_r;

endmodule
